/* rtl/core/twodo_pkg.sv */
// Shared types, constants and tables for the three-wheel odometry block.
package twodo_pkg;

  // Configuration defaults and port sizing
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int PADDR_W          = 5;

  localparam logic [2:0] REG_SIDE_IPT  = 3'd0;
  localparam logic [2:0] REG_BACK_IPT  = 3'd1;
  localparam logic [2:0] REG_LEFT_OFF  = 3'd2;
  localparam logic [2:0] REG_RIGHT_OFF = 3'd3;
  localparam logic [2:0] REG_BACK_OFF  = 3'd4;

  localparam logic [31:0] RST_SIDE_IPT  = 32'd1573;
  localparam logic [31:0] RST_BACK_IPT  = 32'd1573;
  localparam logic [31:0] RST_LEFT_OFF  = 32'd458752;
  localparam logic [31:0] RST_RIGHT_OFF = 32'd458752;
  localparam logic [31:0] RST_BACK_OFF  = 32'd327680;

  // Fixed-point constants (angles in Q30)
  localparam logic [38:0] ARC_MAX     = 39'd274877906943;
  localparam logic [32:0] Q30_TWO_PI  = 33'd6746518852;
  localparam logic [31:0] Q30_PI      = 32'd3373259426;
  localparam logic [30:0] Q30_HALF_PI = 31'd1686629713;
  localparam logic [29:0] CORDIC_INIT = 30'd652032874;

  typedef struct packed {
    logic [31:0]        side_ipt;
    logic [31:0]        back_ipt;
    logic [31:0]        left_off;
    logic [31:0]        right_off;
    logic signed [31:0] back_off;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [31:0] back_count;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
    logic               saturated;
  } pose_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ARC, ST_ANG, ST_BRANCH, ST_SC1, ST_QDIV,
    ST_CHORD, ST_SC2, ST_ROT, ST_ACC, ST_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    CP_IDLE, CP_REDUCE, CP_FOLD, CP_ROTATE
  } cordic_phase_t;

  // atan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0: r = 30'd843314857;
      5'd1: r = 30'd497837830;
      5'd2: r = 30'd263043837;
      5'd3: r = 30'd133525159;
      5'd4: r = 30'd67021687;
      5'd5: r = 30'd33543516;
      5'd6: r = 30'd16775851;
      5'd7: r = 30'd8388437;
      5'd8: r = 30'd4194283;
      5'd9: r = 30'd2097149;
      5'd31: r = 30'd0;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/twodo_cfg.sv */
// APB-style configuration register file for the odometry block.
module twodo_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twodo_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output twodo_pkg::cfg_t               cfg
);

  logic [2:0] idx;
  assign idx    = paddr[twodo_pkg::PADDR_W-1:2];
  assign pready = 1'b1;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.side_ipt  <= twodo_pkg::RST_SIDE_IPT;
      cfg.back_ipt  <= twodo_pkg::RST_BACK_IPT;
      cfg.left_off  <= twodo_pkg::RST_LEFT_OFF;
      cfg.right_off <= twodo_pkg::RST_RIGHT_OFF;
      cfg.back_off  <= $signed(twodo_pkg::RST_BACK_OFF);
    end else if (psel && penable && pwrite) begin
      case (idx)
        twodo_pkg::REG_SIDE_IPT:  cfg.side_ipt  <= pwdata;
        twodo_pkg::REG_BACK_IPT:  cfg.back_ipt  <= pwdata;
        twodo_pkg::REG_LEFT_OFF:  cfg.left_off  <= pwdata;
        twodo_pkg::REG_RIGHT_OFF: cfg.right_off <= pwdata;
        twodo_pkg::REG_BACK_OFF:  cfg.back_off  <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      twodo_pkg::REG_SIDE_IPT:  prdata = cfg.side_ipt;
      twodo_pkg::REG_BACK_IPT:  prdata = cfg.back_ipt;
      twodo_pkg::REG_LEFT_OFF:  prdata = cfg.left_off;
      twodo_pkg::REG_RIGHT_OFF: prdata = cfg.right_off;
      twodo_pkg::REG_BACK_OFF:  prdata = cfg.back_off;
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/twodo_mul.sv */
// Shared two-pass signed multiplier, 40 x 34 bits split into two partial products.
module twodo_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [39:0] a,
  input  logic signed [33:0] b,
  output logic               done,
  output logic signed [73:0] prod
);

  logic signed [39:0] ar;
  logic signed [33:0] br;
  logic signed [54:0] plo;
  logic signed [53:0] phi;
  logic               run1;
  logic               run2;

  assign phi = $signed(ar[39:20]) * br;

  // Sequence the two partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      run1 <= 1'b0;
      run2 <= 1'b0;
      done <= 1'b0;
    end else begin
      run1 <= start;
      run2 <= run1;
      done <= run2;
    end
  end

  // Low partial first, then add the shifted high partial
  always_ff @(posedge clk) begin
    if (start) begin
      ar <= a;
      br <= b;
    end
    if (run1) begin
      plo <= $signed({1'b0, ar[19:0]}) * br;
    end
    if (run2) begin
      prod <= $signed({phi, 20'd0} + 74'(plo));
    end
  end

endmodule

/* rtl/core/twodo_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module twodo_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [37:0] rem_init,
  input  logic [37:0] divisor,
  input  logic [30:0] tail,
  input  logic [4:0]  steps,
  output logic        done,
  output logic [30:0] quot
);

  logic [37:0] rem;
  logic [37:0] dv;
  logic [30:0] tl;
  logic [4:0]  cnt;
  logic        run;
  logic [38:0] trial;
  logic        ge;

  assign trial = {rem, tl[30]};
  assign ge    = trial >= {1'b0, dv};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= steps;
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift in one numerator bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      dv   <= divisor;
      tl   <= tail;
      quot <= 31'd0;
    end else if (run) begin
      rem  <= ge ? 38'(trial - {1'b0, dv}) : trial[37:0];
      quot <= {quot[29:0], ge};
      tl   <= {tl[29:0], 1'b0};
    end
  end

endmodule

/* rtl/core/twodo_cordic.sv */
// Shared CORDIC sine/cosine unit with range reduction, one step per cycle.
module twodo_cordic #(
  parameter int CORDIC_STEPS = twodo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [38:0] angle,
  output logic               done,
  output logic signed [33:0] sin_q30,
  output logic signed [33:0] cos_q30
);

  localparam int Steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam logic [4:0] LastStep = 5'(Steps - 1);
  localparam logic signed [34:0] PiS     = $signed(35'(twodo_pkg::Q30_PI));
  localparam logic signed [34:0] TwoPiS  = $signed(35'(twodo_pkg::Q30_TWO_PI));
  localparam logic signed [34:0] HalfPiS = $signed(35'(twodo_pkg::Q30_HALF_PI));

  twodo_pkg::cordic_phase_t phase, phase_next;

  logic [38:0]        mag;
  logic               neg_in;
  logic [2:0]         k;
  logic [4:0]         i;
  logic signed [35:0] x;
  logic signed [35:0] y;
  logic signed [34:0] z;
  logic               flip;
  logic [38:0]        red_step;
  logic signed [34:0] zr;
  logic signed [34:0] zw;
  logic signed [34:0] zf;
  logic               flip_f;
  logic signed [35:0] xs;
  logic signed [35:0] ys;
  logic signed [34:0] at;

  assign red_step = 39'(twodo_pkg::Q30_TWO_PI) << k;
  assign xs       = x >>> i;
  assign ys       = y >>> i;
  assign at       = $signed({5'd0, twodo_pkg::atan_q30(i)});
  assign sin_q30  = flip ? 34'(-y) : 34'(y);
  assign cos_q30  = flip ? 34'(-x) : 34'(x);

  // Wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    zr = neg_in ? -$signed({1'b0, mag[33:0]}) : $signed({1'b0, mag[33:0]});
    zw = zr;
    if (zw > PiS) zw = zw - TwoPiS;
    if (zw < -PiS) zw = zw + TwoPiS;
    zf     = zw;
    flip_f = 1'b0;
    if (zw > HalfPiS) begin
      zf     = zw - PiS;
      flip_f = 1'b1;
    end else if (zw < -HalfPiS) begin
      zf     = zw + PiS;
      flip_f = 1'b1;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      twodo_pkg::CP_IDLE:   if (start) phase_next = twodo_pkg::CP_REDUCE;
      twodo_pkg::CP_REDUCE: if (k == 3'd0) phase_next = twodo_pkg::CP_FOLD;
      twodo_pkg::CP_FOLD:   phase_next = twodo_pkg::CP_ROTATE;
      twodo_pkg::CP_ROTATE: if (i == LastStep) phase_next = twodo_pkg::CP_IDLE;
      default:              phase_next = twodo_pkg::CP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= twodo_pkg::CP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == twodo_pkg::CP_ROTATE) && (i == LastStep);
    end
  end

  // Datapath: remainder by 2*pi, fold, then rotate
  always_ff @(posedge clk) begin
    case (phase)
      twodo_pkg::CP_IDLE: begin
        if (start) begin
          mag    <= angle[38] ? 39'(-angle) : 39'(angle);
          neg_in <= angle[38];
          k      <= 3'd6;
        end
      end
      twodo_pkg::CP_REDUCE: begin
        if (mag >= red_step) mag <= mag - red_step;
        k <= k - 3'd1;
      end
      twodo_pkg::CP_FOLD: begin
        z    <= zf;
        flip <= flip_f;
        x    <= $signed({6'd0, twodo_pkg::CORDIC_INIT});
        y    <= 36'sd0;
        i    <= 5'd0;
      end
      twodo_pkg::CP_ROTATE: begin
        if (!z[34]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        i <= i + 5'd1;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/three_wheel_odometry_top.sv */
// Three-wheel arc odometry: sequencer around shared multiplier, divider and CORDIC.
//
//   channel   direction  handshake              payload
//   tick      in         tick_valid/tick_stall  twodo_pkg::tick_t
//   pose      out        pose_valid/pose_stall  twodo_pkg::pose_t
//   config    in         APB psel/penable       32-bit registers at 4*i
//
// A tick with a turn makes two CORDIC passes and a quotient division after the
// angle division; a straight tick makes only the second CORDIC pass.
// A reset word goes straight to output. Words are taken one at a time; tick_stall
// is high while a word is in work. A finished pose waits in the output
// register, and the next tick may start meanwhile. rst clears pose and counts.
module three_wheel_odometry_top #(
  parameter int CORDIC_STEPS = twodo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick_valid,
  output logic                          tick_stall,
  input  twodo_pkg::tick_t              tick,
  output logic                          pose_valid,
  input  logic                          pose_stall,
  output twodo_pkg::pose_t              pose,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twodo_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic signed [65:0] ArcHi = $signed(66'(twodo_pkg::ARC_MAX));
  localparam logic signed [65:0] ArcLo = -ArcHi;
  localparam logic signed [25:0] QOne  = 26'sd16777216;

  function automatic logic signed [38:0] clamp_arc(input logic signed [65:0] v);
    logic signed [38:0] r;
    if (v > ArcHi) r = 39'(ArcHi);
    else if (v < ArcLo) r = 39'(ArcLo);
    else r = v[38:0];
    return r;
  endfunction

  twodo_pkg::cfg_t       cfg;
  twodo_pkg::seq_state_t state, state_next;

  logic [1:0]         sub;
  logic               pend;
  logic [31:0]        prev_left, prev_right, prev_back;
  logic [31:0]        cur_l, cur_r, cur_b;
  logic signed [38:0] arc_l, arc_r, arc_b;
  logic signed [31:0] ang;
  logic signed [33:0] s1;
  logic signed [25:0] qv;
  logic signed [38:0] dist_r, dist_b;
  logic signed [27:0] s2, c2;
  logic signed [65:0] part;
  logic signed [41:0] dx, dy;
  logic signed [31:0] acc_x, acc_y, acc_heading;
  twodo_pkg::pose_t   res;
  twodo_pkg::pose_t   pose_r;
  logic               pose_valid_r;

  // Unit hookups
  logic               mul_go, mul_done;
  logic signed [39:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [73:0] mul_prod;
  logic               div_go, div_done;
  logic [37:0]        div_rem, div_dv;
  logic [30:0]        div_tail, div_q;
  logic [4:0]         div_steps;
  logic               cor_go, cor_done;
  logic signed [38:0] cor_angle;
  logic signed [33:0] cor_sin, cor_cos;

  // Shared combinational terms
  logic [32:0]        base;
  logic [31:0]        sel_cur, sel_prev;
  logic signed [32:0] delta;
  logic [32:0]        dmag;
  logic [38:0]        arc_m;
  logic signed [38:0] arc_val;
  logic signed [39:0] diff;
  logic [39:0]        amag;
  logic               ang_sat;
  logic signed [36:0] l_val;
  logic [36:0]        lmag;
  logic [33:0]        s1mag;
  logic               q_sat;
  logic               q_neg;
  logic signed [65:0] chord_sum;
  logic signed [65:0] rot_x, rot_y;
  logic signed [32:0] h_sum;
  logic signed [42:0] x_sum, y_sum;
  logic signed [31:0] h_new, x_new, y_new;
  logic               sat_flag;
  logic               out_free;
  logic               sub_last;

  twodo_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  twodo_mul u_mul (
    .clk, .rst, .start(mul_go), .a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_prod)
  );

  twodo_div u_div (
    .clk, .rst, .start(div_go), .rem_init(div_rem), .divisor(div_dv), .tail(div_tail),
    .steps(div_steps), .done(div_done), .quot(div_q)
  );

  twodo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .start(cor_go), .angle(cor_angle), .done(cor_done),
    .sin_q30(cor_sin), .cos_q30(cor_cos)
  );

  assign base     = {1'b0, cfg.left_off} + {1'b0, cfg.right_off};
  assign out_free = !pose_valid_r || !pose_stall;
  assign sub_last = (state == twodo_pkg::ST_ARC) ? (sub == 2'd2) : (sub == 2'd3);

  // Count change and arc magnitude for the wheel in turn
  always_comb begin
    case (sub)
      2'd0:    begin sel_cur = cur_l; sel_prev = prev_left;  end
      2'd1:    begin sel_cur = cur_r; sel_prev = prev_right; end
      default: begin sel_cur = cur_b; sel_prev = prev_back;  end
    endcase
    delta   = $signed({sel_cur[31], sel_cur}) - $signed({sel_prev[31], sel_prev});
    dmag    = delta[32] ? 33'(-delta) : 33'(delta);
    arc_m   = ($unsigned(mul_prod) > 74'(twodo_pkg::ARC_MAX)) ? twodo_pkg::ARC_MAX
                                                              : mul_prod[38:0];
    arc_val = delta[32] ? -$signed(arc_m) : $signed(arc_m);
  end

  // Turn angle and chord terms
  always_comb begin
    diff    = 40'(arc_r) - 40'(arc_l);
    amag    = diff[39] ? 40'(-diff) : 40'(diff);
    ang_sat = amag >= {base, 7'd0};
    l_val   = $signed({ang, 5'd0});
    lmag    = l_val[36] ? 37'(-l_val) : 37'(l_val);
    s1mag   = s1[33] ? 34'(-s1) : 34'(s1);
    q_sat   = {3'd0, s1mag} >= lmag;
    q_neg   = s1[33] ^ l_val[36];
    chord_sum = part + 66'(mul_prod >>> 29);
    rot_x   = part + 66'(mul_prod);
    rot_y   = part - 66'(mul_prod);
  end

  // Saturating pose update
  always_comb begin
    h_sum    = 33'(acc_heading) + 33'(ang);
    x_sum    = 43'(acc_x) + 43'(dx);
    y_sum    = 43'(acc_y) + 43'(dy);
    sat_flag = 1'b0;
    if (h_sum > 33'sd2147483647) begin h_new = 32'sh7FFFFFFF; sat_flag = 1'b1; end
    else if (h_sum < -33'sd2147483648) begin h_new = 32'sh80000000; sat_flag = 1'b1; end
    else h_new = h_sum[31:0];
    if (x_sum > 43'sd2147483647) begin x_new = 32'sh7FFFFFFF; sat_flag = 1'b1; end
    else if (x_sum < -43'sd2147483648) begin x_new = 32'sh80000000; sat_flag = 1'b1; end
    else x_new = x_sum[31:0];
    if (y_sum > 43'sd2147483647) begin y_new = 32'sh7FFFFFFF; sat_flag = 1'b1; end
    else if (y_sum < -43'sd2147483648) begin y_new = 32'sh80000000; sat_flag = 1'b1; end
    else y_new = y_sum[31:0];
  end

  // Operand selection for the shared units
  always_comb begin
    mul_a = $signed({7'd0, dmag});
    mul_b = (sub == 2'd2) ? $signed({2'd0, cfg.back_ipt}) : $signed({2'd0, cfg.side_ipt});
    if (state == twodo_pkg::ST_CHORD) begin
      case (sub)
        2'd0:    begin mul_a = 40'(arc_r);  mul_b = 34'(qv); end
        2'd1:    begin mul_a = 40'(s1);     mul_b = $signed({2'd0, cfg.right_off}); end
        2'd2:    begin mul_a = 40'(arc_b);  mul_b = 34'(qv); end
        default: begin mul_a = 40'(s1);     mul_b = 34'(cfg.back_off); end
      endcase
    end else if (state == twodo_pkg::ST_ROT) begin
      case (sub)
        2'd0:    begin mul_a = 40'(dist_r); mul_b = 34'(s2); end
        2'd1:    begin mul_a = 40'(dist_b); mul_b = 34'(c2); end
        2'd2:    begin mul_a = 40'(dist_r); mul_b = 34'(c2); end
        default: begin mul_a = 40'(dist_b); mul_b = 34'(s2); end
      endcase
    end
    if (state == twodo_pkg::ST_QDIV) begin
      div_rem   = {4'd0, s1mag};
      div_dv    = {1'b0, lmag};
      div_tail  = 31'd0;
      div_steps = 5'd24;
    end else begin
      div_rem   = {5'd0, amag[39:7]};
      div_dv    = {5'd0, base};
      div_tail  = {amag[6:0], 24'd0};
      div_steps = 5'd31;
    end
    if (state == twodo_pkg::ST_SC1) cor_angle = 39'(l_val);
    else cor_angle = 39'(l_val) + 39'($signed({acc_heading, 6'd0}));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      twodo_pkg::ST_IDLE: begin
        if (tick_valid) state_next = tick.func ? twodo_pkg::ST_OUT : twodo_pkg::ST_ARC;
      end
      twodo_pkg::ST_ARC: if (mul_done && sub_last) state_next = twodo_pkg::ST_ANG;
      twodo_pkg::ST_ANG: begin
        if (base == 33'd0 || ang_sat || div_done) state_next = twodo_pkg::ST_BRANCH;
      end
      twodo_pkg::ST_BRANCH: begin
        state_next = (ang == 32'sd0) ? twodo_pkg::ST_SC2 : twodo_pkg::ST_SC1;
      end
      twodo_pkg::ST_SC1:   if (cor_done) state_next = twodo_pkg::ST_QDIV;
      twodo_pkg::ST_QDIV:  if (q_sat || div_done) state_next = twodo_pkg::ST_CHORD;
      twodo_pkg::ST_CHORD: if (mul_done && sub_last) state_next = twodo_pkg::ST_SC2;
      twodo_pkg::ST_SC2:   if (cor_done) state_next = twodo_pkg::ST_ROT;
      twodo_pkg::ST_ROT:   if (mul_done && sub_last) state_next = twodo_pkg::ST_ACC;
      twodo_pkg::ST_ACC:   state_next = twodo_pkg::ST_OUT;
      twodo_pkg::ST_OUT:   if (out_free) state_next = twodo_pkg::ST_IDLE;
      default:             state_next = twodo_pkg::ST_IDLE;
    endcase
  end

  // Unit launches and handshake outputs
  always_comb begin
    tick_stall = (state != twodo_pkg::ST_IDLE);
    mul_go = !pend && (state == twodo_pkg::ST_ARC || state == twodo_pkg::ST_CHORD ||
                       state == twodo_pkg::ST_ROT);
    div_go = !pend && ((state == twodo_pkg::ST_ANG && base != 33'd0 && !ang_sat) ||
                       (state == twodo_pkg::ST_QDIV && !q_sat));
    cor_go = !pend && (state == twodo_pkg::ST_SC1 || state == twodo_pkg::ST_SC2);
  end

  assign pose_valid = pose_valid_r;
  assign pose       = pose_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= twodo_pkg::ST_IDLE;
      pend         <= 1'b0;
      sub          <= 2'd0;
      pose_valid_r <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_go || div_go || cor_go) pend <= 1'b1;
      else if (mul_done || div_done || cor_done) pend <= 1'b0;
      if (state == twodo_pkg::ST_IDLE) sub <= 2'd0;
      else if (mul_done) sub <= sub_last ? 2'd0 : sub + 2'd1;
      if (state == twodo_pkg::ST_OUT && out_free) pose_valid_r <= 1'b1;
      else if (!pose_stall) pose_valid_r <= 1'b0;
    end
  end

  // Pose and last counts
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left   <= 32'd0;
      prev_right  <= 32'd0;
      prev_back   <= 32'd0;
      acc_x       <= 32'sd0;
      acc_y       <= 32'sd0;
      acc_heading <= 32'sd0;
    end else if (state == twodo_pkg::ST_IDLE && tick_valid && tick.func) begin
      prev_left   <= 32'd0;
      prev_right  <= 32'd0;
      prev_back   <= 32'd0;
      acc_x       <= 32'sd0;
      acc_y       <= 32'sd0;
      acc_heading <= 32'sd0;
    end else if (state == twodo_pkg::ST_ACC) begin
      prev_left   <= cur_l;
      prev_right  <= cur_r;
      prev_back   <= cur_b;
      acc_x       <= x_new;
      acc_y       <= y_new;
      acc_heading <= h_new;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      twodo_pkg::ST_IDLE: begin
        if (tick_valid) begin
          cur_l <= tick.left_count;
          cur_r <= tick.right_count;
          cur_b <= tick.back_count;
          res   <= '0;
        end
      end
      twodo_pkg::ST_ARC: begin
        if (mul_done) begin
          case (sub)
            2'd0:    arc_l <= arc_val;
            2'd1:    arc_r <= arc_val;
            default: arc_b <= arc_val;
          endcase
        end
      end
      twodo_pkg::ST_ANG: begin
        if (base == 33'd0) ang <= 32'sd0;
        else if (ang_sat) ang <= diff[39] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else if (div_done) ang <= diff[39] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      end
      twodo_pkg::ST_BRANCH: begin
        dist_r <= arc_r;
        dist_b <= arc_b;
      end
      twodo_pkg::ST_SC1: if (cor_done) s1 <= cor_sin;
      twodo_pkg::ST_QDIV: begin
        if (q_sat) qv <= q_neg ? -QOne : QOne;
        else if (div_done) begin
          qv <= q_neg ? -$signed({2'd0, div_q[23:0]}) : $signed({2'd0, div_q[23:0]});
        end
      end
      twodo_pkg::ST_CHORD: begin
        if (mul_done) begin
          case (sub)
            2'd0:    part   <= 66'(mul_prod >>> 24);
            2'd1:    dist_r <= clamp_arc(chord_sum);
            2'd2:    part   <= 66'(mul_prod >>> 24);
            default: dist_b <= clamp_arc(chord_sum);
          endcase
        end
      end
      twodo_pkg::ST_SC2: begin
        if (cor_done) begin
          s2 <= 28'(cor_sin >>> 6);
          c2 <= 28'(cor_cos >>> 6);
        end
      end
      twodo_pkg::ST_ROT: begin
        if (mul_done) begin
          case (sub)
            2'd0:    part <= 66'(mul_prod);
            2'd1:    dx   <= 42'(rot_x >>> 24);
            2'd2:    part <= 66'(mul_prod);
            default: dy   <= 42'(rot_y >>> 24);
          endcase
        end
      end
      twodo_pkg::ST_ACC: begin
        res.pose_x       <= x_new;
        res.pose_y       <= y_new;
        res.pose_heading <= h_new;
        res.saturated    <= sat_flag;
      end
      default: ;
    endcase
    if (state == twodo_pkg::ST_OUT && out_free) pose_r <= res;
  end

endmodule

/* rtl/core/twodo_chk.sv */
// Port-level checker for the odometry block, bound to the top level.
module twodo_chk (
  input logic             clk,
  input logic             rst,
  input logic             tick_valid,
  input logic             tick_stall,
  input logic             pose_valid,
  input logic             pose_stall,
  input twodo_pkg::pose_t pose
);

  // A taken word keeps the block busy for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !tick_stall) |=> tick_stall)
    else $error("tick taken but block not busy next cycle");

  // A new pose only appears at the end of work on a word
  a_pose_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(pose_valid) |-> $past(tick_stall))
    else $error("pose appeared without a word in work");

  // The saturated flag comes with a pose value at an int32 limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (pose_valid && pose.saturated) |->
      (pose.pose_x == 32'sh7FFFFFFF || pose.pose_x == 32'sh80000000 ||
       pose.pose_y == 32'sh7FFFFFFF || pose.pose_y == 32'sh80000000 ||
       pose.pose_heading == 32'sh7FFFFFFF || pose.pose_heading == 32'sh80000000))
    else $error("saturated set with no value at its limit");

  // A stalled pose holds
  a_pose_hold: assert property (@(posedge clk) disable iff (rst)
    (pose_valid && pose_stall) |=> (pose_valid && $stable(pose)))
    else $error("stalled pose changed");

endmodule

bind three_wheel_odometry_top twodo_chk u_twodo_chk (.*);
